[rtl/core/bfov_pkg.sv]
// Shared types, constants and the arctangent table of the bearing field-of-view test.
// No dependencies; imported by every module of the block.
`default_nettype none

package bfov_pkg;

    // Angle of the CORDIC unit: degrees with 20 fraction bits
    localparam int TAB_FRAC = 20;
    localparam int TAB_LEN  = 24;

    // CORDIC vector width (signed) and angle accumulator width (signed)
    localparam int XW = 58;
    localparam int ZW = 28;

    // Border reduction: offset border values and their approximate quotients
    localparam int VW = 24;
    localparam int QW = 16;
    localparam int RW = 16;

    // Where a vector lying on an axis points
    typedef enum logic [1:0] {
        AX_ZERO,
        AX_QUARTER,
        AX_HALF,
        AX_THREEQ
    } t_axis;

    // Per-item data that rides alongside the CORDIC vector
    typedef struct packed {
        logic            is_axis;
        t_axis           axis_sel;
        logic            neg_x;
        logic            neg_y;
        logic [VW-1:0]   v_l;
        logic [VW-1:0]   v_r;
        logic [QW-1:0]   q_l;
        logic [QW-1:0]   q_r;
    } t_side;

    // atan(2^-i) in degrees, 20 fraction bits, rounded to nearest
    function automatic logic signed [ZW-1:0] bfov_atan(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(47185920);
            5'd1:    v = ZW'(27855475);
            5'd2:    v = ZW'(14718068);
            5'd3:    v = ZW'(7471121);
            5'd4:    v = ZW'(3750058);
            5'd5:    v = ZW'(1876857);
            5'd6:    v = ZW'(938658);
            5'd7:    v = ZW'(469357);
            5'd8:    v = ZW'(234682);
            5'd9:    v = ZW'(117342);
            5'd10:   v = ZW'(58671);
            5'd11:   v = ZW'(29335);
            5'd12:   v = ZW'(14668);
            5'd13:   v = ZW'(7334);
            5'd14:   v = ZW'(3667);
            5'd15:   v = ZW'(1833);
            5'd16:   v = ZW'(917);
            5'd17:   v = ZW'(458);
            5'd18:   v = ZW'(229);
            5'd19:   v = ZW'(115);
            5'd20:   v = ZW'(57);
            5'd21:   v = ZW'(29);
            5'd22:   v = ZW'(14);
            5'd23:   v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bfov_prep.sv]
// Front end: coordinate differences, quadrant and axis flags, CORDIC start vector,
// offset sector borders and their reciprocal quotients. Two pipeline stages. Uses bfov_pkg.
`default_nettype none

module bfov_prep
    import bfov_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [COORD_BITS-1:0]        i_ox,
    input  wire logic [COORD_BITS-1:0]        i_oy,
    input  wire logic [COORD_BITS-1:0]        i_tx,
    input  wire logic [COORD_BITS-1:0]        i_ty,
    input  wire logic [15:0]                  i_facing,
    input  wire logic [15:0]                  i_view_width,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [XW-1:0]              o_x,
    output logic signed [XW-1:0]              o_y,
    output t_side                             o_side
);

    localparam int CB     = COORD_BITS;
    localparam int FULL   = 360 << ANGLE_FRAC_BITS;
    localparam int MOD2   = 2 * FULL;
    // multiple of the border modulus that keeps facing*2 - width non-negative
    localparam int OFS    = MOD2 * (65535 / MOD2 + 1);
    localparam int RECIP  = (1 << VW) / MOD2;
    localparam int SHIFT0 = 54 - CB;

    logic               r_v1;
    logic               r_v2;
    logic               rdy1;
    logic               rdy2;

    logic signed [CB:0] n_dx;
    logic signed [CB:0] n_dy;
    logic [VW-1:0]      n_vl;
    logic [VW-1:0]      n_vr;
    logic signed [CB:0] r_dx;
    logic signed [CB:0] r_dy;
    logic [VW-1:0]      r_vl;
    logic [VW-1:0]      r_vr;

    logic [CB:0]        ax;
    logic [CB:0]        ay;
    logic [VW+RW-1:0]   prod_l;
    logic [VW+RW-1:0]   prod_r;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    t_side              n_side;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    t_side              r_side;

    // stage handshakes: a stage loads when empty or when its item moves on
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // stage 1: differences and offset borders
    always_comb begin
        n_dx = $signed({i_tx[CB-1], i_tx}) - $signed({i_ox[CB-1], i_ox});
        n_dy = $signed({i_ty[CB-1], i_ty}) - $signed({i_oy[CB-1], i_oy});
        n_vl = VW'({i_facing, 1'b0}) - VW'(i_view_width) + VW'(OFS);
        n_vr = VW'({i_facing, 1'b0}) + VW'(i_view_width);
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_vl <= n_vl;
            r_vr <= n_vr;
        end
    end

    // stage 2: magnitudes, axis decode, quotient estimates (may be one low)
    always_comb begin
        ax = r_dx[CB] ? (CB+1)'(-r_dx) : (CB+1)'(r_dx);
        ay = r_dy[CB] ? (CB+1)'(-r_dy) : (CB+1)'(r_dy);
        n_x = $signed(XW'(ax) << SHIFT0);
        n_y = $signed(XW'(ay) << SHIFT0);

        prod_l = (VW+RW)'(r_vl) * (VW+RW)'(RECIP);
        prod_r = (VW+RW)'(r_vr) * (VW+RW)'(RECIP);

        n_side.neg_x    = r_dx[CB];
        n_side.neg_y    = r_dy[CB];
        n_side.is_axis  = (r_dx == '0) || (r_dy == '0);
        n_side.axis_sel = AX_ZERO;
        if (r_dx == '0) begin
            if (r_dy == '0)    n_side.axis_sel = AX_ZERO;
            else if (r_dy[CB]) n_side.axis_sel = AX_THREEQ;
            else               n_side.axis_sel = AX_QUARTER;
        end else if (r_dy == '0) begin
            n_side.axis_sel = r_dx[CB] ? AX_HALF : AX_ZERO;
        end
        n_side.v_l = r_vl;
        n_side.v_r = r_vr;
        n_side.q_l = prod_l[VW+QW-1:VW];
        n_side.q_r = prod_r[VW+QW-1:VW];
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_side <= n_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_side = r_side;

endmodule

`default_nettype wire

[rtl/core/bfov_cell.sv]
// One CORDIC vectoring cell: a single micro-rotation by atan(2^-STAGE), registered,
// with its own valid bit and handshake. Uses bfov_pkg.
`default_nettype none

module bfov_cell
    import bfov_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic signed [XW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [XW-1:0]      o_x,
    output logic signed [XW-1:0]      o_y,
    output logic signed [ZW-1:0]      o_z,
    output t_side                     o_side
);

    logic                 r_valid;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [ZW-1:0] step;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // rotate toward y = 0; shifts are floor shifts
    always_comb begin
        xs   = i_x >>> STAGE;
        ys   = i_y >>> STAGE;
        step = bfov_atan(5'(STAGE));
        if (!i_y[XW-1] && (i_y != '0)) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + step;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

`default_nettype wire

[rtl/core/bfov_post.sv]
// Back end: clamp and round the CORDIC angle, restore the quadrant, finish the border
// reduction and run the sector test. Two pipeline stages, the second is the output register.
// Uses bfov_pkg.
`default_nettype none

module bfov_post
    import bfov_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [ZW-1:0] i_z,
    input  wire t_side                i_side,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_inside,
    output logic [15:0]               o_bearing
);

    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam int MOD2    = 2 * FULL;
    localparam int BW      = $clog2(FULL) + 1;
    localparam int SH      = TAB_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] ZMAX = ZW'(90 << TAB_FRAC);
    localparam logic signed [ZW-1:0] ZRND = ZW'(1 << (SH - 1));
    localparam logic [BW-1:0] FULL_B    = BW'(FULL);
    localparam logic [BW-1:0] QUARTER_B = BW'(FULL / 4);
    localparam logic [BW-1:0] HALF_B    = BW'(FULL / 2);
    localparam logic [BW-1:0] THREEQ_B  = BW'(3 * (FULL / 4));
    localparam logic [VW-1:0] MOD2_V    = VW'(MOD2);

    logic                 r_v1;
    logic                 r_v2;
    logic                 rdy1;
    logic                 rdy2;

    logic signed [ZW-1:0] zc;
    logic [ZW-1:0]        zr;
    logic [BW-1:0]        a;
    logic [BW-1:0]        rq;
    logic [BW-1:0]        n_b;
    logic [VW-1:0]        n_rl;
    logic [VW-1:0]        n_rr;
    logic [BW-1:0]        r_b;
    logic [VW-1:0]        r_rl;
    logic [VW-1:0]        r_rr;

    logic [VW-1:0]        bl;
    logic [VW-1:0]        br;
    logic [VW-1:0]        b2;
    logic                 n_inside;
    logic                 r_inside;
    logic [15:0]          r_bear;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // stage 1: angle to bearing, border remainders in [0, 2*modulus)
    always_comb begin
        zc = i_z;
        if (i_z[ZW-1])      zc = '0;
        else if (i_z > ZMAX) zc = ZMAX;
        zr = zc + ZRND;
        a  = BW'(zr >> SH);

        if (i_side.neg_x) rq = i_side.neg_y ? HALF_B + a : HALF_B - a;
        else              rq = i_side.neg_y ? FULL_B - a : a;
        if (rq >= FULL_B) rq = rq - FULL_B;

        if (i_side.is_axis) begin
            unique case (i_side.axis_sel)
                AX_ZERO:    n_b = '0;
                AX_QUARTER: n_b = QUARTER_B;
                AX_HALF:    n_b = HALF_B;
                AX_THREEQ:  n_b = THREEQ_B;
            endcase
        end else begin
            n_b = rq;
        end

        n_rl = i_side.v_l - VW'(i_side.q_l) * MOD2_V;
        n_rr = i_side.v_r - VW'(i_side.q_r) * MOD2_V;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_b  <= n_b;
            r_rl <= n_rl;
            r_rr <= n_rr;
        end
    end

    // stage 2: final correction and sector test in half angle units
    always_comb begin
        bl = (r_rl >= MOD2_V) ? r_rl - MOD2_V : r_rl;
        br = (r_rr >= MOD2_V) ? r_rr - MOD2_V : r_rr;
        b2 = VW'(r_b) << 1;
        // wrapped sector: both borders themselves count as outside
        n_inside = ((b2 >= bl) && (b2 <= br)) || ((bl > br) && ((b2 < br) || (b2 > bl)));
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_inside <= n_inside;
            r_bear   <= 16'(r_b);
        end
    end

    assign o_inside  = r_inside;
    assign o_bearing = r_bear;

endmodule

`default_nettype wire

[rtl/core/bearing_field_of_view_test_top.sv]
// Bearing field-of-view test: front end, a chain of CORDIC_STAGES vectoring cells, back end.
// Pipeline: two front-end stages, one register per cell, two back-end stages.
// Throughput: one item per cycle unless stalled; every stage has its own valid bit, so the chain
// keeps accepting items into empty stages while a finished result waits at the output register.
// Reset (synchronous, active low) clears all stage valid bits; no clearing pass is needed.
// Depends on bfov_pkg, bfov_prep, bfov_cell and bfov_post.
`default_nettype none

module bearing_field_of_view_test_top
    import bfov_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 7,
    localparam int IN_W = ((4 * COORD_BITS + 32 + 7) / 8) * 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // observer_x, observer_y, target_x, target_y (COORD_BITS each), facing[16],
    // view_width[16], zero padding
    input  wire logic [IN_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  wire logic            i_m_axis_tready,
    // inside_res[1], bearing[16], zero padding[7]
    output logic [23:0]          o_m_axis_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int N      = CORDIC_STAGES;
    localparam int FULL_T = 360 << ANGLE_FRAC_BITS;

    logic                 cv [0:N];
    logic                 cr [0:N];
    logic signed [XW-1:0] cx [0:N];
    logic signed [XW-1:0] cy [0:N];
    logic signed [ZW-1:0] cz [0:N];
    t_side                cs [0:N];

    logic                 in_sector;
    logic [15:0]          bearing;

    // front end
    bfov_prep #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_ox         (i_s_axis_tdata[CB-1:0]),
        .i_oy         (i_s_axis_tdata[2*CB-1:CB]),
        .i_tx         (i_s_axis_tdata[3*CB-1:2*CB]),
        .i_ty         (i_s_axis_tdata[4*CB-1:3*CB]),
        .i_facing     (i_s_axis_tdata[4*CB+15:4*CB]),
        .i_view_width (i_s_axis_tdata[4*CB+31:4*CB+16]),
        .o_valid      (cv[0]),
        .i_ready      (cr[0]),
        .o_x          (cx[0]),
        .o_y          (cy[0]),
        .o_side       (cs[0])
    );

    assign cz[0] = '0;

    // CORDIC cell chain
    for (genvar k = 0; k < N; k++) begin : g_cell
        bfov_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cv[k]),
            .o_ready (cr[k]),
            .i_x     (cx[k]),
            .i_y     (cy[k]),
            .i_z     (cz[k]),
            .i_side  (cs[k]),
            .o_valid (cv[k+1]),
            .i_ready (cr[k+1]),
            .o_x     (cx[k+1]),
            .o_y     (cy[k+1]),
            .o_z     (cz[k+1]),
            .o_side  (cs[k+1])
        );
    end

    // back end and output register
    bfov_post #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cv[N]),
        .o_ready   (cr[N]),
        .i_z       (cz[N]),
        .i_side    (cs[N]),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_inside  (in_sector),
        .o_bearing (bearing)
    );

    assign o_m_axis_tdata = {7'd0, bearing, in_sector};

    // no valid output right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // input side can only block when the whole chain is full and the output is stalled
    a_block_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input blocked while the chain has room");

    // bearing stays below a full turn when it fits the field
    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((ANGLE_FRAC_BITS > 7) || (o_m_axis_tdata[16:1] < 16'(FULL_T))))
        else $error("bearing out of range");

endmodule

`default_nettype wire

[tb/sv/bearing_fov_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the bearing field-of-view test: watches both stream channels, predicts
// each result from the accepted query and compares it with what the block returns.
// Self-contained; no package or RTL function is used for the prediction.

module bearing_fov_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // observer_x, observer_y, target_x, target_y, facing, view_width (16 each)
    input  wire logic [95:0] i_s_tdata,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // inside_res[1], bearing[16], zero padding[7]
    input  wire logic [23:0] i_m_tdata,
    output int               o_pending,
    output int               o_errors
);

    // Angles in 1/128 degree
    localparam longint FULL_TURN = 46080;
    localparam longint HALF_TURN = FULL_TURN / 2;
    localparam longint QUARTER   = FULL_TURN / 4;
    localparam int     STAGES    = 16;
    localparam int     TAB_FRAC  = 20;
    localparam int     OUT_FRAC  = 7;
    localparam int     PRE_SHIFT = 54 - 16;

    typedef struct packed {
        logic        in_sector;
        logic [15:0] bearing;
    } t_view;

    t_view due_views[$];
    t_view want;
    t_view got;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 47185920;
            1:       return 27855475;
            2:       return 14718068;
            3:       return 7471121;
            4:       return 3750058;
            5:       return 1876857;
            6:       return 938658;
            7:       return 469357;
            8:       return 234682;
            9:       return 117342;
            10:      return 58671;
            11:      return 29335;
            12:      return 14668;
            13:      return 7334;
            14:      return 3667;
            15:      return 1833;
            default: return 0;
        endcase
    endfunction

    // First-quadrant angle of (ax, ay), both positive, by CORDIC vectoring
    function automatic longint quadrant_angle(input longint ax, input longint ay);
        longint x, y, z, xs, ys;
        x = ax <<< PRE_SHIFT;
        y = ay <<< PRE_SHIFT;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< TAB_FRAC)) z = longint'(90) <<< TAB_FRAC;
        // round half up to the output resolution
        return (z + (longint'(1) <<< (TAB_FRAC - OUT_FRAC - 1))) >>> (TAB_FRAC - OUT_FRAC);
    endfunction

    // Bearing of (dx, dy) in [0, FULL_TURN); axes are exact
    function automatic longint bearing_of(input longint dx, input longint dy);
        longint a, r;
        if (dx == 0) begin
            if (dy == 0) return 0;
            return (dy > 0) ? QUARTER : 3 * QUARTER;
        end
        if (dy == 0) return (dx > 0) ? 0 : HALF_TURN;
        a = quadrant_angle(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (dx < 0) r = (dy > 0) ? HALF_TURN - a : HALF_TURN + a;
        else        r = (dy > 0) ? a : FULL_TURN - a;
        if (r >= FULL_TURN) r = r - FULL_TURN;
        return r;
    endfunction

    function automatic longint wrap_double_turn(input longint v);
        return ((v % (2 * FULL_TURN)) + 2 * FULL_TURN) % (2 * FULL_TURN);
    endfunction

    // Sector test in half units; in the wrapped case both borders are outside
    function automatic logic sector_contains(input longint b, input longint f,
                                             input longint w);
        longint b2, l, r;
        b2 = 2 * b;
        l  = wrap_double_turn(2 * f - w);
        r  = wrap_double_turn(2 * f + w);
        return (b2 >= l && b2 <= r) || (l > r && (b2 < r || b2 > l));
    endfunction

    function automatic t_view predict_view(input logic [95:0] q);
        longint ox, oy, tx, ty, b;
        t_view  v;
        ox = longint'($signed(q[15:0]));
        oy = longint'($signed(q[31:16]));
        tx = longint'($signed(q[47:32]));
        ty = longint'($signed(q[63:48]));
        b  = bearing_of(tx - ox, ty - oy);
        v.bearing   = b[15:0];
        v.in_sector = sector_contains(b, longint'(q[79:64]), longint'(q[95:80]));
        return v;
    endfunction

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    // Predict on each accepted query, compare on each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                due_views.push_back(predict_view(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.in_sector = i_m_tdata[0];
                got.bearing   = i_m_tdata[16:1];
                if (due_views.size() == 0) begin
                    $error("result with no query outstanding: inside_res %0d bearing %0d",
                           got.in_sector, got.bearing);
                    o_errors++;
                end else begin
                    want = due_views.pop_front();
                    if (got.in_sector !== want.in_sector) begin
                        $error("inside_res: expected %0d, actual %0d",
                               want.in_sector, got.in_sector);
                        o_errors++;
                    end
                    if (got.bearing !== want.bearing) begin
                        $error("bearing: expected %0d, actual %0d",
                               want.bearing, got.bearing);
                        o_errors++;
                    end
                end
            end
            o_pending = due_views.size();
        end
    end

endmodule

[tb/sv/tb_bearing_field_of_view_test_top.sv]
`timescale 1ns / 1ps
// Top of the bearing field-of-view testbench: clock, reset, query stimulus, output
// back-pressure, watchdog and verdict. Depends on bearing_field_of_view_test_top and
// bearing_fov_checker.

module tb_bearing_field_of_view_test_top;

    localparam int  LATENCY      = 20;
    localparam int  RANDOM_ITEMS = 1250;
    localparam int  QUIET_FROM   = 1150;
    localparam int  STALL_LIMIT  = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          pending;
    int          errors;
    bit          quiet_phase;
    int          idle_cycles;

    bearing_field_of_view_test_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    bearing_fov_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [95:0] pack_query(input logic [15:0] ox, input logic [15:0] oy,
                                               input logic [15:0] tx, input logic [15:0] ty,
                                               input logic [15:0] f, input logic [15:0] w);
        return {w, f, ty, tx, oy, ox};
    endfunction

    function automatic logic [15:0] extreme_coord();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // Random query: a mix of coincident, axis-aligned, short, extreme and fully random vectors
    function automatic logic [95:0] random_query();
        logic [15:0] ox, oy, tx, ty, f, w;
        int          kind;
        ox   = 16'($urandom);
        oy   = 16'($urandom);
        tx   = 16'($urandom);
        ty   = 16'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                tx = ox;
                ty = oy;
            end
            1: begin
                if ($urandom_range(0, 1)) tx = ox;
                else                      ty = oy;
            end
            2: begin
                tx = ox + 16'($signed($urandom_range(0, 16)) - 8);
                ty = oy + 16'($signed($urandom_range(0, 16)) - 8);
            end
            3: begin
                ox = extreme_coord();
                oy = extreme_coord();
                tx = extreme_coord();
                ty = extreme_coord();
            end
            default: ;
        endcase
        f = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46079));
        case ($urandom_range(0, 9))
            0:       w = 16'd0;
            1:       w = 16'd46080;
            2:       w = 16'($urandom);
            3:       w = 16'($urandom_range(0, 64));
            default: w = 16'($urandom_range(0, 46080));
        endcase
        return pack_query(ox, oy, tx, ty, f, w);
    endfunction

    // Offer one query, with an occasional gap first; otherwise valid stays high between items
    task automatic send_query(input logic [95:0] q);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = q;
        @(posedge i_clk);
        while (!(s_tvalid && s_tready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output back-pressure in bursts, none in the final stretch
    initial begin : ready_gen
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet_phase) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end else if ($urandom_range(0, 9) == 0) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else                                                  idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        quiet_phase = 1'b0;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: axes, coincident points, coordinate extremes, sector borders
        send_query(pack_query(0, 0, 0, 0, 0, 0));
        send_query(pack_query(0, 0, 100, 0, 0, 256));
        send_query(pack_query(5, 5, 5, 900, 11520, 0));
        // full-turn width: only the border bearing counts
        send_query(pack_query(0, 0, -1, 0, 0, 46080));
        // wrapped sector, bearing on the left border
        send_query(pack_query(0, 0, 0, -1, 42000, 14880));
        // wrapped sector, bearing on the right border
        send_query(pack_query(0, 0, 7, 0, 45952, 256));
        send_query(pack_query(0, 0, 7, 0, 46000, 400));
        send_query(pack_query(-32768, -32768, 32767, 32767, 5760, 1000));
        send_query(pack_query(32767, 32767, -32768, -32768, 28800, 2));
        send_query(pack_query(-32768, 32767, 32767, -32768, 40320, 128));
        send_query(pack_query(32767, -32768, -32768, 32767, 17280, 46079));
        send_query(pack_query(0, 0, 32767, 1, 0, 2));
        send_query(pack_query(0, 0, 1, 32767, 11520, 4));
        send_query(pack_query(0, 0, -32768, -1, 23040, 64));
        // facing beyond a full turn wraps
        send_query(pack_query(0, 0, 1, -1, 65535, 65535));
        send_query(pack_query(0, 0, -1, 1, 46079, 46080));
        send_query(pack_query(100, -200, -300, 400, 0, 0));
        send_query(pack_query(0, 0, 3, 4, 12345, 65535));
        send_query(pack_query(0, 0, -4, -3, 46079, 1));
        send_query(pack_query(1, 1, 2, 2, 5760, 0));
        send_query(pack_query(0, 0, -32768, 0, 23040, 46080));
        send_query(pack_query(0, 0, 0, 32767, 11520, 46080));

        // Random queries; twice the sender drains the pipeline first
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400 || n == 800) begin
                s_tvalid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            if (n == QUIET_FROM) quiet_phase = 1'b1;
            send_query(random_query());
        end
        s_tvalid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bfov_pkg.sv
rtl/core/bfov_prep.sv
rtl/core/bfov_cell.sv
rtl/core/bfov_post.sv
rtl/core/bearing_field_of_view_test_top.sv
tb/sv/bearing_fov_checker.sv
tb/sv/tb_bearing_field_of_view_test_top.sv
